/* design/aals_pkg.sv */
// Shared types and constants for the acro angle limit setpoint block.
package aals_pkg;

    // Axes that have angle limits; axes at or above this index pass through.
    localparam int LIMITED_AXES = 2;

    // Field widths of the streams.
    localparam int AXIS_W    = 2;
    localparam int PILOT_W   = 16;
    localparam int ANGLE_W   = 12;
    localparam int GYRO_W    = 16;
    localparam int RATE_W    = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Configuration port widths and register widths.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int GAIN_W     = 8;
    localparam int LOOK_W     = 8;
    localparam int LIMIT_W    = 7;
    localparam int TRIM_W     = 10;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd75;
    localparam logic [LOOK_W-1:0]  LOOK_RST  = 8'd50;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd20;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLED     = 3'd0,
        CFG_GAIN        = 3'd1,
        CFG_LOOKAHEAD   = 3'd2,
        CFG_LIMIT_ROLL  = 3'd3,
        CFG_LIMIT_PITCH = 3'd4,
        CFG_TRIM_ROLL   = 3'd5,
        CFG_TRIM_PITCH  = 3'd6
    } cfg_idx_t;

    // Fixed-point constants: rates in 1/16 dps, angles in decidegrees.
    localparam int RATE_CLAMP    = 16000;
    localparam int LOOK_RATE_CAP = 8000;
    localparam int PROJ_DEN      = 12800000;

    // Projection words are held at this signed width.
    localparam int PW = 40;
    typedef logic signed [PW-1:0] proj_t;

    // Scaling: result = floor(|q| * gain / 80000000), done as a shift by 512
    // and a reciprocal multiply by 1/156250 with a one-step correction.
    localparam int PROD_W      = PW + GAIN_W;
    localparam logic [PROD_W-1:0] SAT_LIMIT = 48'd1280080000000;
    localparam int DIV_SHIFT   = 9;
    localparam int X_W         = 32;
    localparam int DIV_REM     = 156250;
    localparam int RECIP       = 450359962;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 46;
    localparam int RP_W        = X_W + RECIP_W;
    localparam int QMAG_W      = 14;

    // Per-item control that rides alongside the arithmetic.
    typedef struct packed {
        logic signed [PILOT_W-1:0] pilot;
        logic                      beyond;
        logic                      a_pos;
        logic                      proj_hit;
        logic                      limited;
        logic                      q_neg;
    } side_t;

endpackage

/* design/aals_scale.sv */
// Pipelined gain scaling and constant division of the correction magnitude.
module aals_scale
    import aals_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PW-1:0]     in_absq,
    input  logic [GAIN_W-1:0] in_gain,
    input  side_t             in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QMAG_W-1:0] out_mag,
    output logic              out_sat,
    output side_t             out_side
);

    localparam int NS = 5;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;
    side_t         side_reg [NS];

    logic [PROD_W-1:0] s1_prod_reg;
    logic [PROD_W-1:0] s1_prod_next;
    logic              s2_sat_reg;
    logic [X_W-1:0]    s2_x_reg;
    logic              s3_sat_reg;
    logic [X_W-1:0]    s3_x_reg;
    logic [QMAG_W-1:0] s3_qe_reg;
    logic [RP_W-1:0]   s3_rp_next;
    logic              s4_sat_reg;
    logic [X_W-1:0]    s4_x_reg;
    logic [QMAG_W-1:0] s4_qe_reg;
    logic [X_W-1:0]    s4_qd_reg;
    logic [X_W-1:0]    s4_qd_next;
    logic              s5_sat_reg;
    logic [QMAG_W-1:0] s5_mag_reg;
    logic [X_W-1:0]    s5_rem_next;
    logic [QMAG_W-1:0] s5_mag_next;

    // A stage may load when it is empty or its successor loads.
    always_comb begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // Valid bits and control travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= in_side;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Products and the reciprocal estimate.
    always_comb begin
        s1_prod_next = PROD_W'(in_absq) * PROD_W'(in_gain);
        s3_rp_next   = RP_W'(s2_x_reg) * RP_W'(RECIP);
        s4_qd_next   = X_W'(s3_qe_reg) * X_W'(DIV_REM);
        s5_rem_next  = s4_x_reg - s4_qd_reg;
        s5_mag_next  = (s5_rem_next >= X_W'(DIV_REM)) ? s4_qe_reg + QMAG_W'(1) : s4_qe_reg;
    end

    // Stage 1: magnitude times gain.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_prod_reg <= s1_prod_next;
        end
    end

    // Stage 2: saturation check and the power-of-two part of the divide.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_sat_reg <= (s1_prod_reg >= SAT_LIMIT);
            s2_x_reg   <= s1_prod_reg[DIV_SHIFT +: X_W];
        end
    end

    // Stage 3: quotient estimate, at most one below the true quotient.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_sat_reg <= s2_sat_reg;
            s3_x_reg   <= s2_x_reg;
            s3_qe_reg  <= s3_rp_next[RECIP_SHIFT +: QMAG_W];
        end
    end

    // Stage 4: back-multiply the estimate.
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_sat_reg <= s3_sat_reg;
            s4_x_reg   <= s3_x_reg;
            s4_qe_reg  <= s3_qe_reg;
            s4_qd_reg  <= s4_qd_next;
        end
    end

    // Stage 5: correct the estimate from the remainder.
    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_sat_reg <= s4_sat_reg;
            s5_mag_reg <= s5_mag_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_mag   = s5_mag_reg;
    assign out_sat   = s5_sat_reg;
    assign out_side  = side_reg[NS-1];

endmodule

/* design/acro_angle_limit_setpoint.sv */
// Top level of the acro angle limit setpoint block.
//
// Each input transaction carries one axis sample: the axis code on s_tuser and
// the pilot rate, attitude angle and gyro rate on s_tdata. Roll and pitch
// samples are checked against their angle limits while the limiter is
// enabled; any other axis passes its pilot rate through. Each input
// transaction gives exactly one output transaction, in order, with the rate
// setpoint on m_tdata and the limiting flag on m_tuser.
// Registers are written over the cfg port, one per cycle with cfg_wr_en high.
// The user must write them only while no sample is in flight; the block
// itself does not enforce this. Throughput is one sample per cycle while
// the receiver takes results. The pipeline depth is set by the projection
// multiplies and the constant divide that follows the gain multiply.
// Each stage holds its data while the stage after it is full and stalled, so
// a stalled receiver only blocks input once every stage is occupied; gaps
// in the stream are squeezed out. Reset clears all stages and returns the
// registers to their defaults with the limiter disabled.
module acro_angle_limit_setpoint
    import aals_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Bits from 0 up: pilot_rate[15:0], attitude_angle[27:16], gyro_rate[43:28].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Bits from 0 up: axis_sel[1:0].
    input  logic [AXIS_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Bits from 0 up: rate_out[15:0].
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Bits from 0 up: limiting[0].
    output logic                  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NS = 7;

    // Configuration registers.
    logic                     enabled_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [LOOK_W-1:0]        look_reg;
    logic [LIMIT_W-1:0]       limit_roll_reg;
    logic [LIMIT_W-1:0]       limit_pitch_reg;
    logic signed [TRIM_W-1:0] trim_roll_reg;
    logic signed [TRIM_W-1:0] trim_pitch_reg;

    // Pipeline control.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    // Stage A: registered input.
    logic [AXIS_W-1:0]         sa_axis_reg;
    logic signed [PILOT_W-1:0] sa_pilot_reg;
    logic signed [ANGLE_W-1:0] sa_att_reg;
    logic signed [GYRO_W-1:0]  sa_gyro_reg;

    // Stage B: trimmed angle, limit, gyro cap.
    logic signed [ANGLE_W:0]   sb_a_reg, sb_a_next;
    logic [10:0]               sb_ld_reg, sb_ld_next;
    logic [12:0]               sb_m_reg, sb_m_next;
    logic signed [GYRO_W-1:0]  sb_gyro_reg;
    side_t                     sb_side_reg, sb_side_next;
    logic signed [TRIM_W-1:0]  sb_trim;
    logic [LIMIT_W-1:0]        sb_lim;
    logic [ANGLE_W:0]          sb_absa;
    logic signed [GYRO_W:0]    sb_g17;
    logic [GYRO_W:0]           sb_absg;
    logic                      sb_axis_ok;

    // Stage C: first products.
    logic signed [29:0] sc_gm_reg, sc_gm_next;
    proj_t              sc_ad_reg, sc_ad_next;
    proj_t              sc_ldd_reg, sc_ldd_next;
    side_t              sc_side_reg;

    // Stage D: lookahead product and the beyond-limit error.
    proj_t sd_gml_reg, sd_gml_next;
    proj_t sd_qb_reg, sd_qb_next;
    proj_t sd_ad_reg;
    proj_t sd_ldd_reg;
    side_t sd_side_reg;

    // Stage E: projection.
    proj_t se_p_reg, se_p_next;
    proj_t se_ldd_reg;
    proj_t se_nldd_reg, se_nldd_next;
    proj_t se_qb_reg;
    side_t se_side_reg;

    // Stage F: projection test and signed error.
    proj_t sf_q_reg, sf_q_next;
    side_t sf_side_reg, sf_side_next;
    logic  sf_sr;

    // Stage G: error magnitude.
    logic [PW-1:0] sg_absq_reg, sg_absq_next;
    side_t         sg_side_reg, sg_side_next;

    // Scaling unit and output stage.
    logic              scale_in_ready;
    logic              sc_out_valid;
    logic [QMAG_W-1:0] sc_out_mag;
    logic              sc_out_sat;
    side_t             sc_out_side;
    logic              en_out;
    logic              m_tvalid_reg;
    logic [RATE_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;
    logic [QMAG_W-1:0]        o_cmag;
    logic signed [RATE_W-1:0] o_corr_pos;
    logic signed [RATE_W-1:0] o_corr;
    logic signed [RATE_W-1:0] o_rate;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg     <= 1'b0;
            gain_reg        <= GAIN_RST;
            look_reg        <= LOOK_RST;
            limit_roll_reg  <= LIMIT_RST;
            limit_pitch_reg <= LIMIT_RST;
            trim_roll_reg   <= '0;
            trim_pitch_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ENABLED:     enabled_reg     <= cfg_wdata[0];
                CFG_GAIN:        gain_reg        <= cfg_wdata[GAIN_W-1:0];
                CFG_LOOKAHEAD:   look_reg        <= cfg_wdata[LOOK_W-1:0];
                CFG_LIMIT_ROLL:  limit_roll_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_LIMIT_PITCH: limit_pitch_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_TRIM_ROLL:   trim_roll_reg   <= signed'(cfg_wdata[TRIM_W-1:0]);
                CFG_TRIM_PITCH:  trim_pitch_reg  <= signed'(cfg_wdata[TRIM_W-1:0]);
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its successor loads.
    always_comb begin
        en[NS] = scale_in_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage A: take the transaction apart.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sa_axis_reg  <= s_tuser;
            sa_pilot_reg <= signed'(s_tdata[15:0]);
            sa_att_reg   <= signed'(s_tdata[27:16]);
            sa_gyro_reg  <= signed'(s_tdata[43:28]);
        end
    end

    // Stage B logic: trim, limit in decidegrees, limit test, capped |gyro|.
    always_comb begin
        sb_axis_ok = (sa_axis_reg == AXIS_ROLL || sa_axis_reg == AXIS_PITCH) &&
                     (32'(sa_axis_reg) < LIMITED_AXES);
        sb_trim    = (sa_axis_reg == AXIS_ROLL) ? trim_roll_reg : trim_pitch_reg;
        sb_lim     = (sa_axis_reg == AXIS_ROLL) ? limit_roll_reg : limit_pitch_reg;
        sb_a_next  = (ANGLE_W+1)'(sa_att_reg) - (ANGLE_W+1)'(sb_trim);
        sb_ld_next = 11'(sb_lim) * 11'd10;
        sb_absa    = sb_a_next[ANGLE_W] ? unsigned'(-sb_a_next) : unsigned'(sb_a_next);
        sb_g17     = (GYRO_W+1)'(sa_gyro_reg);
        sb_absg    = sb_g17[GYRO_W] ? unsigned'(-sb_g17) : unsigned'(sb_g17);
        sb_m_next  = (sb_absg > (GYRO_W+1)'(LOOK_RATE_CAP)) ? 13'(LOOK_RATE_CAP)
                                                           : sb_absg[12:0];
        sb_side_next.pilot    = sa_pilot_reg;
        sb_side_next.beyond   = sb_absa > (ANGLE_W+1)'(sb_ld_next);
        sb_side_next.a_pos    = !sb_a_next[ANGLE_W] && (sb_a_next != '0);
        sb_side_next.proj_hit = 1'b0;
        sb_side_next.limited  = enabled_reg && sb_axis_ok;
        sb_side_next.q_neg    = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sb_a_reg    <= sb_a_next;
            sb_ld_reg   <= sb_ld_next;
            sb_m_reg    <= sb_m_next;
            sb_gyro_reg <= sa_gyro_reg;
            sb_side_reg <= sb_side_next;
        end
    end

    // Stage C logic: gyro times capped rate, angle and limit scaled to the projection unit.
    always_comb begin
        sc_gm_next  = 30'(sb_gyro_reg) * 30'(signed'({1'b0, sb_m_reg}));
        sc_ad_next  = PW'(sb_a_reg) * PW'(PROJ_DEN);
        sc_ldd_next = PW'(signed'({1'b0, sb_ld_reg})) * PW'(PROJ_DEN);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            sc_gm_reg   <= sc_gm_next;
            sc_ad_reg   <= sc_ad_next;
            sc_ldd_reg  <= sc_ldd_next;
            sc_side_reg <= sb_side_reg;
        end
    end

    // Stage D logic: apply lookahead time; error toward the limit when beyond it.
    always_comb begin
        sd_gml_next = PW'(sc_gm_reg) * PW'(signed'({1'b0, look_reg}));
        sd_qb_next  = (sc_side_reg.a_pos ? sc_ldd_reg : -sc_ldd_reg) - sc_ad_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sd_gml_reg  <= sd_gml_next;
            sd_qb_reg   <= sd_qb_next;
            sd_ad_reg   <= sc_ad_reg;
            sd_ldd_reg  <= sc_ldd_reg;
            sd_side_reg <= sc_side_reg;
        end
    end

    // Stage E logic: projected angle.
    always_comb begin
        se_p_next    = sd_gml_reg + sd_ad_reg;
        se_nldd_next = -sd_ldd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            se_p_reg    <= se_p_next;
            se_ldd_reg  <= sd_ldd_reg;
            se_nldd_reg <= se_nldd_next;
            se_qb_reg   <= sd_qb_reg;
            se_side_reg <= sd_side_reg;
        end
    end

    // Stage F logic: the projection overrides only when it passes the limit
    // on the side the pilot is steering toward (zero counts as negative).
    always_comb begin
        sf_sr        = !se_side_reg.pilot[PILOT_W-1] && (se_side_reg.pilot != '0);
        sf_side_next = se_side_reg;
        sf_side_next.proj_hit = !se_side_reg.beyond &&
                                ((sf_sr && (se_p_reg > se_ldd_reg)) ||
                                 (!sf_sr && (se_p_reg < se_nldd_reg)));
        if (se_side_reg.beyond) begin
            sf_q_next = se_qb_reg;
        end else begin
            sf_q_next = (sf_sr ? se_ldd_reg : se_nldd_reg) - se_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            sf_q_reg    <= sf_q_next;
            sf_side_reg <= sf_side_next;
        end
    end

    // Stage G logic: split the error into sign and magnitude.
    always_comb begin
        sg_absq_next       = sf_q_reg[PW-1] ? unsigned'(-sf_q_reg) : unsigned'(sf_q_reg);
        sg_side_next       = sf_side_reg;
        sg_side_next.q_neg = sf_q_reg[PW-1];
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            sg_absq_reg <= sg_absq_next;
            sg_side_reg <= sg_side_next;
        end
    end

    // Correction magnitude: floor(|error| * gain / (100 * PROJ_DEN / 16)).
    aals_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NS-1]),
        .in_ready  (scale_in_ready),
        .in_absq   (sg_absq_reg),
        .in_gain   (gain_reg),
        .in_side   (sg_side_reg),
        .out_valid (sc_out_valid),
        .out_ready (en_out),
        .out_mag   (sc_out_mag),
        .out_sat   (sc_out_sat),
        .out_side  (sc_out_side)
    );

    // Output logic: saturate, sign, and choose between pilot and correction.
    always_comb begin
        o_cmag     = sc_out_sat ? QMAG_W'(RATE_CLAMP) : sc_out_mag;
        o_corr_pos = signed'(RATE_W'(o_cmag));
        o_corr     = sc_out_side.q_neg ? -o_corr_pos : o_corr_pos;
        o_rate     = sc_out_side.pilot;
        if (sc_out_side.limited) begin
            if (sc_out_side.beyond) begin
                // Pilot input passes only when it steers back harder.
                if (sc_out_side.a_pos) begin
                    o_rate = (sc_out_side.pilot < o_corr) ? sc_out_side.pilot : o_corr;
                end else begin
                    o_rate = (sc_out_side.pilot > o_corr) ? sc_out_side.pilot : o_corr;
                end
            end else if (sc_out_side.proj_hit) begin
                o_rate = o_corr;
            end
        end
        m_tdata_next = unsigned'(o_rate);
        m_tuser_next = sc_out_side.limited && (o_rate != sc_out_side.pilot);
    end

    // Output register; it loads whenever it is empty or being taken.
    assign en_out = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= sc_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* tb/sv/acro_angle_limit_setpoint_tb.sv */
// Self-checking testbench for the acro angle limit setpoint block.
module acro_angle_limit_setpoint_tb;
    import aals_pkg::*;

    // Axis codes beyond the limited ones, and a register index that does not exist.
    localparam logic [AXIS_W-1:0]     AXIS_YAW       = 2'd2;
    localparam logic [AXIS_W-1:0]     AXIS_SPARE     = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic                     limiting;
    } rate_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [AXIS_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the block's registers and per-axis flags.
    logic                     shadow_enabled     = 1'b0;
    logic [GAIN_W-1:0]        shadow_gain        = GAIN_RST;
    logic [LOOK_W-1:0]        shadow_lookahead   = LOOK_RST;
    logic [LIMIT_W-1:0]       shadow_limit_roll  = LIMIT_RST;
    logic [LIMIT_W-1:0]       shadow_limit_pitch = LIMIT_RST;
    logic signed [TRIM_W-1:0] shadow_trim_roll   = '0;
    logic signed [TRIM_W-1:0] shadow_trim_pitch  = '0;
    logic                     limit_flags [2]    = '{1'b0, 1'b0};

    rate_result_t pending_rates [$];
    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 30;
    int rx_idle_pct = 30;
    int rx_hold_len = 0;
    int rx_hold_seq = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;

    acro_angle_limit_setpoint dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a period of 4.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Saturate a rate to the correction clamp.
    function automatic longint clamp_rate(input longint v);
        if (v > RATE_CLAMP)
            return RATE_CLAMP;
        if (v < -RATE_CLAMP)
            return -RATE_CLAMP;
        return v;
    endfunction

    // Work out the limited rate setpoint for one sample and update the axis flag.
    function automatic rate_result_t limit_rate(input logic [AXIS_W-1:0] axis,
                                                input logic signed [PILOT_W-1:0] pilot_in,
                                                input logic signed [ANGLE_W-1:0] angle_in,
                                                input logic signed [GYRO_W-1:0] gyro_in);
        rate_result_t res;
        longint pilot, gyro, a, ld, g, corr, rate, mag, proj, sp, sr, bound;
        pilot = pilot_in;
        gyro = gyro_in;
        rate = pilot;
        res.limiting = 1'b0;
        if (shadow_enabled && axis < 2 && axis < LIMITED_AXES) begin
            if (axis == AXIS_ROLL) begin
                a = longint'(angle_in) - longint'(shadow_trim_roll);
                ld = longint'(shadow_limit_roll) * 10;
            end else begin
                a = longint'(angle_in) - longint'(shadow_trim_pitch);
                ld = longint'(shadow_limit_pitch) * 10;
            end
            g = longint'(shadow_gain);
            if (((a < 0) ? -a : a) > ld) begin
                // Beyond the limit: pull back, letting through only pilot input that helps.
                sp = (a > 0) ? 1 : -1;
                corr = clamp_rate(((ld * sp - a) * g * 16) / 100);
                if (sp > 0)
                    rate = (pilot < corr) ? pilot : corr;
                else
                    rate = (pilot > corr) ? pilot : corr;
            end else begin
                // Within the limit: project the angle ahead, scaled by the gyro rate.
                mag = (gyro < 0) ? -gyro : gyro;
                if (mag > LOOK_RATE_CAP)
                    mag = LOOK_RATE_CAP;
                proj = gyro * mag * longint'(shadow_lookahead) + a * longint'(PROJ_DEN);
                sp = (proj > 0) ? 1 : -1;
                sr = (pilot > 0) ? 1 : -1;
                bound = ld * longint'(PROJ_DEN);
                if (((proj < 0) ? -proj : proj) > bound && sp == sr)
                    rate = clamp_rate(((bound * sp - proj) * g * 16)
                                      / (longint'(100) * longint'(PROJ_DEN)));
            end
            limit_flags[axis[0]] = (rate != pilot);
            res.limiting = limit_flags[axis[0]];
        end
        res.rate = rate[RATE_W-1:0];
        return res;
    endfunction

    // Write one register while the block is idle and mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_ENABLED: begin
                shadow_enabled = value[0];
                if (!value[0]) begin
                    limit_flags[0] = 1'b0;
                    limit_flags[1] = 1'b0;
                end
            end
            CFG_GAIN:        shadow_gain        = value[GAIN_W-1:0];
            CFG_LOOKAHEAD:   shadow_lookahead   = value[LOOK_W-1:0];
            CFG_LIMIT_ROLL:  shadow_limit_roll  = value[LIMIT_W-1:0];
            CFG_LIMIT_PITCH: shadow_limit_pitch = value[LIMIT_W-1:0];
            CFG_TRIM_ROLL:   shadow_trim_roll   = value[TRIM_W-1:0];
            CFG_TRIM_PITCH:  shadow_trim_pitch  = value[TRIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Write every register, the enable last.
    task automatic apply_settings(input logic en, input logic [GAIN_W-1:0] gain,
                                  input logic [LOOK_W-1:0] look,
                                  input logic [LIMIT_W-1:0] lim_roll, lim_pitch,
                                  input logic signed [TRIM_W-1:0] trim_roll, trim_pitch);
        write_reg(CFG_GAIN, CFG_DATA_W'(gain));
        write_reg(CFG_LOOKAHEAD, CFG_DATA_W'(look));
        write_reg(CFG_LIMIT_ROLL, CFG_DATA_W'(lim_roll));
        write_reg(CFG_LIMIT_PITCH, CFG_DATA_W'(lim_pitch));
        write_reg(CFG_TRIM_ROLL, trim_roll);
        write_reg(CFG_TRIM_PITCH, trim_pitch);
        write_reg(CFG_ENABLED, CFG_DATA_W'(en));
    endtask

    // Offer one sample after a random gap and record its expected result on acceptance.
    task automatic send_sample(input logic [AXIS_W-1:0] axis,
                               input logic signed [PILOT_W-1:0] pilot,
                               input logic signed [ANGLE_W-1:0] angle,
                               input logic signed [GYRO_W-1:0] gyro);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, gyro, angle, pilot};
        s_tuser  <= axis;
        do
            @(posedge aclk);
        while (!s_tready);
        pending_rates.push_back(limit_rate(axis, pilot, angle, gyro));
        @(negedge aclk);
    endtask

    // Stop offering and wait until every expected result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_rates.size() != 0);
    endtask

    // Random sample, weighted toward angles near the limit and rates near the cap.
    task automatic send_random_sample();
        int sel, ld, trim, ang;
        logic [AXIS_W-1:0] axis;
        logic signed [PILOT_W-1:0] pilot;
        logic signed [GYRO_W-1:0] gyro;
        sel = $urandom_range(99);
        if (sel < 42)
            axis = AXIS_ROLL;
        else if (sel < 84)
            axis = AXIS_PITCH;
        else
            axis = AXIS_W'($urandom_range(3));
        ld = 10 * ((axis == AXIS_PITCH) ? int'(shadow_limit_pitch) : int'(shadow_limit_roll));
        trim = (axis == AXIS_PITCH) ? int'(shadow_trim_pitch) : int'(shadow_trim_roll);

        sel = $urandom_range(99);
        if (sel < 40)
            ang = trim + ($urandom_range(1) ? ld : -ld) + int'($urandom_range(300)) - 150;
        else if (sel < 80)
            ang = int'($urandom_range(3600)) - 1800;
        else
            ang = int'($urandom_range(4095)) - 2048;
        if (ang > 2047)
            ang = 2047;
        if (ang < -2048)
            ang = -2048;

        sel = $urandom_range(99);
        if (sel < 40)
            gyro = GYRO_W'(int'($urandom_range(18000)) - 9000);
        else if (sel < 70)
            gyro = GYRO_W'($urandom_range(65535));
        else if (sel < 80)
            case ($urandom_range(3))
                0: gyro = -16'sd32768;
                1: gyro = 16'sd32767;
                2: gyro = 16'sd0;
                default: gyro = 16'sd8000;
            endcase
        else
            gyro = GYRO_W'(int'($urandom_range(1000)) - 500);

        sel = $urandom_range(99);
        if (sel < 50)
            pilot = PILOT_W'($urandom_range(65535));
        else if (sel < 70)
            pilot = PILOT_W'(int'($urandom_range(4000)) - 2000);
        else if (sel < 80)
            pilot = 16'sd0;
        else if (sel < 90)
            pilot = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        else
            pilot = PILOT_W'(int'($urandom_range(33000)) - 16500);

        send_sample(axis, pilot, ANGLE_W'(ang), gyro);
    endtask

    // Receiver: random idling, or a long hold-off counted here when one is requested.
    always @(negedge aclk) begin
        if (rx_hold_seen != rx_hold_seq) begin
            rx_hold_seen <= rx_hold_seq;
            rx_hold_left <= rx_hold_len;
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each output transaction with the oldest expected result.
    always @(posedge aclk) begin
        rate_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rates.size() == 0) begin
                $display("%0t: unexpected result rate_out %0d limiting %0b",
                         $time, $signed(m_tdata), m_tuser);
                error_count++;
            end else begin
                want = pending_rates.pop_front();
                if (m_tdata !== want.rate) begin
                    $display("%0t: rate_out expected %0d actual %0d",
                             $time, want.rate, $signed(m_tdata));
                    error_count++;
                end
                if (m_tuser !== want.limiting) begin
                    $display("%0t: limiting expected %0b actual %0b",
                             $time, want.limiting, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // With the limiter disabled after reset, every axis passes through.
    task automatic test_disabled_passthrough();
        send_sample(AXIS_ROLL, 16'sd32767, 12'sd1800, -16'sd32768);
        send_sample(AXIS_PITCH, -16'sd32768, -12'sd1800, 16'sd32767);
        send_sample(AXIS_SPARE, 16'sd1234, 12'sd2047, 16'sd0);
        drain_results();
    endtask

    // Hand-picked samples around the limit, the projection and the zero sign rule.
    task automatic test_limits_directed();
        apply_settings(1'b1, GAIN_RST, LOOK_RST, LIMIT_RST, LIMIT_RST, 10'sd0, 10'sd0);
        // Beyond the limit on both sides, with and without helping pilot input.
        send_sample(AXIS_ROLL, 16'sd1000, 12'sd500, 16'sd0);
        send_sample(AXIS_ROLL, -16'sd16000, 12'sd500, 16'sd0);
        send_sample(AXIS_PITCH, -16'sd32768, -12'sd1800, 16'sd32767);
        send_sample(AXIS_PITCH, 16'sd32767, -12'sd2048, -16'sd32768);
        send_sample(AXIS_ROLL, 16'sd0, 12'sd201, 16'sd0);
        // Exactly at the limit stays within.
        send_sample(AXIS_ROLL, 16'sd500, 12'sd200, 16'sd0);
        // Projection passes the limit in the pilot's direction, then against it.
        send_sample(AXIS_ROLL, 16'sd100, 12'sd150, 16'sd8000);
        send_sample(AXIS_ROLL, -16'sd100, 12'sd150, 16'sd8000);
        send_sample(AXIS_PITCH, 16'sd0, -12'sd150, -16'sd8000);
        send_sample(AXIS_PITCH, 16'sd0, 12'sd0, 16'sd0);
        send_sample(AXIS_PITCH, -16'sd5, 12'sd0, 16'sd32767);
        // Axes without a limit pass through.
        send_sample(AXIS_YAW, 16'sd32767, 12'sd1800, 16'sd8000);
        send_sample(AXIS_SPARE, -16'sd32768, -12'sd1800, -16'sd8000);
        drain_results();
        // A write to a missing register changes nothing.
        write_reg(CFG_UNUSED_IDX, 10'h3FF);
        send_sample(AXIS_ROLL, 16'sd1000, 12'sd500, 16'sd0);
        // Trim shifts the angle; a zero limit puts any nonzero angle beyond it.
        drain_results();
        apply_settings(1'b1, 8'd255, 8'd250, 7'd0, 7'd127, 10'sd300, -10'sd512);
        send_sample(AXIS_ROLL, 16'sd0, 12'sd0, 16'sd0);
        send_sample(AXIS_ROLL, 16'sd50, 12'sd300, 16'sd40);
        send_sample(AXIS_PITCH, 16'sd32767, 12'sd2047, 16'sd32767);
        send_sample(AXIS_PITCH, 16'sd100, -12'sd2048, 16'sd0);
        drain_results();
        // Disabling clears the flags and passes everything through.
        write_reg(CFG_ENABLED, 10'd0);
        send_sample(AXIS_ROLL, 16'sd1000, 12'sd500, 16'sd0);
        send_sample(AXIS_PITCH, 16'sd1000, 12'sd1800, 16'sd8000);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_backpressure();
        apply_settings(1'b1, GAIN_RST, LOOK_RST, LIMIT_RST, LIMIT_RST, 10'sd0, 10'sd0);
        tx_idle_pct = 0;
        rx_hold_len = 300;
        rx_hold_seq = rx_hold_seq + 1;
        repeat (80)
            send_random_sample();
        tx_idle_pct = 30;
        drain_results();
    endtask

    // The sender pauses in the middle until every result is back.
    task automatic test_sender_pause();
        repeat (30)
            send_random_sample();
        drain_results();
        repeat (30)
            send_random_sample();
        drain_results();
    endtask

    // One phase of random samples under fixed settings.
    task automatic test_random_phase(input int count, input logic en,
                                     input logic [GAIN_W-1:0] gain,
                                     input logic [LOOK_W-1:0] look,
                                     input logic [LIMIT_W-1:0] lim_roll, lim_pitch,
                                     input logic signed [TRIM_W-1:0] trim_roll, trim_pitch);
        apply_settings(en, gain, look, lim_roll, lim_pitch, trim_roll, trim_pitch);
        repeat (count)
            send_random_sample();
        drain_results();
    endtask

    // Random in-range settings followed by random samples.
    task automatic test_random_settings(input int count);
        test_random_phase(count, 1'b1, GAIN_W'($urandom_range(25, 255)),
                          LOOK_W'($urandom_range(10, 250)),
                          LIMIT_W'($urandom_range(10, 80)), LIMIT_W'($urandom_range(10, 80)),
                          TRIM_W'(int'($urandom_range(600)) - 300),
                          TRIM_W'(int'($urandom_range(600)) - 300));
    endtask

    // A stretch with no idling on either side, under the largest settings that the random phases draw.
    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_phase(120, 1'b1, 8'd255, 8'd250, 7'd80, 7'd80, 10'sd300, 10'sd300);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
    endtask

    initial begin
        repeat (10)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_disabled_passthrough();
        test_limits_directed();
        test_backpressure();
        test_sender_pause();
        test_random_phase(250, 1'b1, GAIN_RST, LOOK_RST, LIMIT_RST, LIMIT_RST, 10'sd0, 10'sd0);
        test_random_phase(250, 1'b1, 8'd25, 8'd10, 7'd10, 7'd10, -10'sd300, -10'sd300);
        test_full_rate();
        test_random_phase(200, 1'b1, 8'd255, 8'd250, 7'd80, 7'd80, 10'sd300, 10'sd300);
        test_random_phase(200, 1'b1, 8'd0, 8'd255, 7'd127, 7'd0, -10'sd512, 10'sd511);
        test_random_settings(200);
        test_random_settings(200);
        test_random_settings(200);
        test_random_phase(100, 1'b0, 8'd100, 8'd100, 7'd30, 7'd30, 10'sd50, -10'sd50);

        // Let anything still in flight come out before the verdict.
        repeat (30)
            @(negedge aclk);
        if (error_count == 0 && pending_rates.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/aals_pkg.sv
design/aals_scale.sv
design/acro_angle_limit_setpoint.sv
tb/sv/acro_angle_limit_setpoint_tb.sv
